// ===== hw/rtl/utf8_stream_decoder_core_defines.svh =====
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// checked at every edge outside reset
`define UTF8SD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define UTF8SD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/utf8sd_pkg.sv =====
`default_nettype none

package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 32;
    localparam int ACC_W  = 21;
    localparam int LEN_W  = 3;
    localparam int LEFT_W = 2;

    localparam logic [CP_W-1:0] ERROR_VALUE_RESET = '1;

    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [3:0] NIB_CONT_LO = 4'h8;
    localparam logic [3:0] NIB_TWO_LO  = 4'hC;
    localparam logic [3:0] NIB_THREE   = 4'hE;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic             is_error;
        logic [LEN_W-1:0] seq_bytes;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder_core.sv =====
// utf8 stream decoder: one byte request accepted per cycle unless the input stalls
// a result appears in the output register in the cycle after its last byte is accepted
// the sequence state registers update once per accepted byte
// input stalls only while a finished result waits under output stall
// rst_n async low: sequence state cleared, no result held, error_value set to all ones
`default_nettype none

module utf8_stream_decoder_core
    import utf8sd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] byte_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CP_W-1:0]        codepoint,
    output logic                   is_error,
    output logic [LEN_W-1:0]       seq_bytes,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CP_W-1:0]   cfg_data
);

    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              bad_reg, bad_next;
    logic [LEN_W-1:0]  total_len_reg, total_len_next;
    logic [CP_W-1:0]   error_value_reg;
    logic              out_valid_reg;
    result_t           result_reg, result_next;
    logic              emit;
    logic              accept;
    logic              cont_bad;
    logic [ACC_W-1:0]  acc_shift;
    logic [LEFT_W-1:0] left_dec;
    logic [3:0]        nib;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign nib       = byte_in[7:4];
    assign cont_bad  = byte_in[7:6] != CONT_TAG;
    assign acc_shift = {acc_reg[ACC_W-7:0], byte_in[5:0]};
    assign left_dec  = bytes_left_reg - 2'd1;

    always_comb
    begin
        bytes_left_next       = bytes_left_reg;
        acc_next              = acc_reg;
        bad_next              = bad_reg;
        total_len_next        = total_len_reg;
        emit                  = 1'b0;
        result_next.codepoint = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        result_next.is_error  = 1'b0;
        result_next.seq_bytes = LEN_ONE;
        if (bytes_left_reg == '0)
        begin
            if (nib < NIB_CONT_LO)
            begin
                emit = 1'b1;
            end
            else if (nib < NIB_TWO_LO)
            begin
                emit                  = 1'b1;
                result_next.codepoint = error_value_reg;
                result_next.is_error  = 1'b1;
            end
            else
            begin
                bad_next = 1'b0;
                if (nib < NIB_THREE)
                begin
                    acc_next        = {{(ACC_W-5){1'b0}}, byte_in[4:0]};
                    bytes_left_next = 2'd1;
                    total_len_next  = LEN_TWO;
                end
                else if (nib == NIB_THREE)
                begin
                    acc_next        = {{(ACC_W-4){1'b0}}, byte_in[3:0]};
                    bytes_left_next = 2'd2;
                    total_len_next  = LEN_THREE;
                end
                else
                begin
                    acc_next        = {{(ACC_W-3){1'b0}}, byte_in[2:0]};
                    bytes_left_next = 2'd3;
                    total_len_next  = LEN_FOUR;
                end
            end
        end
        else
        begin
            bytes_left_next = left_dec;
            acc_next        = acc_shift;
            bad_next        = bad_reg || cont_bad;
            if (left_dec == '0)
            begin
                emit                  = 1'b1;
                result_next.is_error  = bad_reg || cont_bad;
                result_next.codepoint = (bad_reg || cont_bad) ? error_value_reg
                                      : {{(CP_W-ACC_W){1'b0}}, acc_shift};
                result_next.seq_bytes = total_len_reg;
                acc_next              = '0;
                bad_next              = 1'b0;
                total_len_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= '0;
            acc_reg         <= '0;
            bad_reg         <= 1'b0;
            total_len_reg   <= '0;
            error_value_reg <= ERROR_VALUE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                error_value_reg <= cfg_data;
            end
            if (accept)
            begin
                bytes_left_reg <= bytes_left_next;
                acc_reg        <= acc_next;
                bad_reg        <= bad_next;
                total_len_reg  <= total_len_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign codepoint = result_reg.codepoint;
    assign is_error  = result_reg.is_error;
    assign seq_bytes = result_reg.seq_bytes;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8sd_checker.sv =====
`default_nettype none
`include "utf8_stream_decoder_core_defines.svh"

module utf8sd_checker
    import utf8sd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [CP_W-1:0]  codepoint,
    input wire logic             is_error,
    input wire logic [LEN_W-1:0] seq_bytes
);

    `UTF8SD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `UTF8SD_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(codepoint) && $stable(is_error) && $stable(seq_bytes), "stalled result changed")
    `UTF8SD_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled with no waiting result")
    `UTF8SD_ASSERT(a_len_range, clk, rst_n, out_valid |-> seq_bytes >= LEN_ONE && seq_bytes <= LEN_FOUR, "sequence length out of range")
    `UTF8SD_ASSERT(a_cp_width, clk, rst_n, out_valid && !is_error |-> codepoint[CP_W-1:ACC_W] == '0, "decoded codepoint wider than 21 bits")

endmodule

bind utf8_stream_decoder_core utf8sd_checker u_utf8sd_checker (.*);

`default_nettype wire
